// ----- rtl/core/bra_pkg.sv -----
// bra_pkg: shared constants, codes and controller/datapath interface types
// for the bitmap run allocator; depends on nothing
package bra_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_W    = 32;
  localparam int MAP_WORDS = MAP_BITS / WORD_W;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int IDX_W     = $clog2(MAP_BITS);
  localparam int LEN_W     = IDX_W + 1;
  localparam int MB_W      = 10;

  typedef enum logic [1:0] {
    CMD_TEST  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_code_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef enum logic [2:0] {
    RES_OK    = 3'd0,
    RES_RANGE = 3'd1,
    RES_MISS  = 3'd2,
    RES_BIT   = 3'd3,
    RES_FOUND = 3'd4
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      clear;
    logic      rd_single;
    logic      wr_bit;
    logic      scan_start;
    logic      scan_step;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_code_t kind;
    logic      range_bad;
    logic      trivial;
    logic      found;
    logic      last;
    logic      out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/bra_ctrl.sv -----
// bra_ctrl: command sequencer for the bitmap run allocator
// depends on bra_pkg
module bra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  bra_pkg::dp_stat_t stat,
  output bra_pkg::dp_cmd_t  cmd,
  output logic              idle
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_kind = bra_pkg::RES_OK;
    idle         = 1'b0;
    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          bra_pkg::CMD_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_kind = bra_pkg::RES_OK;
            state_next   = S_DONE;
          end
          bra_pkg::CMD_SCAN: begin
            if (stat.trivial) begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = bra_pkg::RES_MISS;
              state_next   = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            if (stat.range_bad) begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = bra_pkg::RES_RANGE;
              state_next   = S_DONE;
            end else begin
              cmd.rd_single = 1'b1;
              state_next    = S_ACCESS;
            end
          end
        endcase
      end
      S_ACCESS: begin
        cmd.res_set = 1'b1;
        if (stat.kind == bra_pkg::CMD_TEST) begin
          cmd.res_kind = bra_pkg::RES_BIT;
        end else begin
          cmd.wr_bit   = 1'b1;
          cmd.res_kind = bra_pkg::RES_OK;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = bra_pkg::RES_FOUND;
          state_next   = S_DONE;
        end else if (stat.last) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = bra_pkg::RES_MISS;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/bra_dpath.sv -----
// bra_dpath: bitmap word memory, row valid bits, run scan logic and
// result/output registers; depends on bra_pkg
module bra_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  bra_pkg::dp_cmd_t              cmd,
  output bra_pkg::dp_stat_t             stat,
  input  logic [1:0]                    in_cmd,
  input  logic [bra_pkg::IDX_W-1:0]     in_idx,
  input  logic                          in_wv,
  input  logic [bra_pkg::LEN_W-1:0]     in_len,
  input  logic [bra_pkg::LEN_W-1:0]     used,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [bra_pkg::IDX_W-1:0]     out_start,
  output logic                          out_bit
);

  localparam int W  = bra_pkg::WORD_W;
  localparam int AW = bra_pkg::ADDR_W;
  localparam int BW = bra_pkg::BIT_W;
  localparam int LW = bra_pkg::LEN_W;
  localparam int IW = bra_pkg::IDX_W;

  logic [1:0]    it_cmd;
  logic [IW-1:0] it_idx;
  logic          it_wv;
  logic [LW-1:0] it_len;

  logic [W-1:0]  mem [bra_pkg::MAP_WORDS];
  logic [bra_pkg::MAP_WORDS-1:0] row_valid;
  logic [W-1:0]  rdata;
  logic          rrow_ok;
  logic [AW-1:0] rword;
  logic          rd_ok;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] carry;

  logic [1:0]    res_status;
  logic [IW-1:0] res_start;
  logic          res_bit;

  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [W-1:0]  wd;
  logic [W-1:0]  wd_new;
  logic [W-1:0]  eff;
  logic [LW-1:0] base;
  logic [LW-1:0] run [W];
  logic          hit;
  logic [BW-1:0] pos;
  logic [LW-1:0] found_start;
  logic [LW-1:0] used_m1;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_cmd <= in_cmd;
      it_idx <= in_idx;
      it_wv  <= in_wv;
      it_len <= in_len;
    end
  end

  assign rd_en = cmd.rd_single | cmd.scan_start | cmd.scan_step;

  always_comb begin
    if (cmd.rd_single) begin
      raddr = it_idx[IW-1:BW];
    end else if (cmd.scan_start) begin
      raddr = '0;
    end else begin
      raddr = rd_ptr;
    end
  end

  // word memory, read data registered
  always_ff @(posedge clk) begin
    if (cmd.wr_bit) begin
      mem[it_idx[IW-1:BW]] <= wd_new;
    end
    if (rd_en) begin
      rdata   <= mem[raddr];
      rrow_ok <= row_valid[raddr];
      rword   <= raddr;
    end
  end

  // a row that is not valid reads as all free
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_valid <= '0;
    end else if (cmd.wr_bit) begin
      row_valid[it_idx[IW-1:BW]] <= 1'b1;
    end
  end

  assign wd = rrow_ok ? rdata : '0;

  always_comb begin
    wd_new = wd;
    wd_new[it_idx[BW-1:0]] = it_wv;
  end

  // scan pointer and carried zero run
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.scan_start | cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_ptr <= AW'(1);
      carry  <= '0;
    end else if (cmd.scan_step) begin
      rd_ptr <= rd_ptr + AW'(1);
      if (rd_ok) begin
        carry <= run[W-1];
      end
    end
  end

  // per-bit run length ending at each position; bits past the end count as used
  assign base = {1'b0, rword, {BW{1'b0}}};

  always_comb begin
    logic          seen;
    logic [BW-1:0] last1;
    for (int j = 0; j < W; j++) begin
      eff[j] = wd[j] | ((base + LW'(j)) >= used);
    end
    for (int j = 0; j < W; j++) begin
      seen  = 1'b0;
      last1 = '0;
      for (int k = 0; k < W; k++) begin
        if (k <= j && eff[k]) begin
          seen  = 1'b1;
          last1 = BW'(k);
        end
      end
      run[j] = seen ? LW'(j - int'(last1)) : carry + LW'(j + 1);
    end
    hit = 1'b0;
    pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (run[j] >= it_len) begin
        hit = 1'b1;
        pos = BW'(j);
      end
    end
  end

  assign found_start = base + LW'(pos) + LW'(1) - it_len;
  assign used_m1     = used - LW'(1);

  // results
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= bra_pkg::ST_OK;
      res_start  <= '0;
      res_bit    <= 1'b0;
      case (cmd.res_kind)
        bra_pkg::RES_RANGE: res_status <= bra_pkg::ST_RANGE;
        bra_pkg::RES_MISS:  res_status <= bra_pkg::ST_NOT_FOUND;
        bra_pkg::RES_BIT:   res_bit    <= wd[it_idx[BW-1:0]];
        bra_pkg::RES_FOUND: res_start  <= found_start[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_start  <= res_start;
      out_bit    <= res_bit;
    end
  end

  always_comb begin
    stat.kind      = bra_pkg::cmd_code_t'(it_cmd);
    stat.range_bad = {1'b0, it_idx} >= used;
    stat.trivial   = (it_len == '0) || (used == '0);
    stat.found     = rd_ok & hit;
    stat.last      = rd_ok && (rword == used_m1[IW-1:BW]);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- rtl/core/bitmap_run_allocator_core.sv -----
// bitmap_run_allocator_core: top level of the bitmap run allocator
// depends on bra_pkg, bra_ctrl, bra_dpath
//
// usage:
//   slave stream takes one command item at a time: tuser carries the
//   command (test, write, scan, clear), tdata the bit index, write value
//   and run length. the master stream returns exactly one result item per
//   command: tuser carries the status, tdata the run start and tested bit.
//   the apb port holds map_bytes (bytes of map in use) at address 0; the
//   user must write it only while the block is idle (not enforced here).
// map memory and scans:
//   the map lives in a 128 x 32 word memory with one read port. test and
//   write go from accept through decode, word read and result.
//   a scan reads one word per cycle and checks all 32 bits of it at once;
//   it reads at most 128 words and stops at the first word that completes
//   the run. clear goes from decode straight to result.
// reset and stalls:
//   reset clears the per-row valid bits at once, so the map reads all free
//   with no clearing pass; map_bytes returns to 512. a stalled receiver
//   holds the result in the output register; the next item is accepted
//   meanwhile and its result waits until the register frees up.
module bitmap_run_allocator_core (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // bit_index[11:0], write_value[12], run_length[25:13]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // start_index[11:0], bit_value[12]
  output logic [1:0]  m_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = bra_pkg::IDX_W;
  localparam int LW = bra_pkg::LEN_W;
  localparam int MW = bra_pkg::MB_W;

  logic [MW-1:0] map_bytes;
  logic [LW-1:0] used;
  logic          idle;
  logic          in_fire;
  logic [IW-1:0] out_start;
  logic          out_bit;

  bra_pkg::dp_cmd_t  dp_cmd;
  bra_pkg::dp_stat_t dp_stat;

  // register index is paddr[2]; only index 0 exists
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_bytes <= MW'(512);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      map_bytes <= pwdata[MW-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32 - MW){1'b0}}, map_bytes};

  // bits in use: eight per byte, capped at the map size
  assign used = ({3'b000, map_bytes} >= LW'(bra_pkg::MAP_BITS / 8))
              ? LW'(bra_pkg::MAP_BITS)
              : {map_bytes[LW-4:0], 3'b000};

  assign s_tready = idle;
  assign in_fire  = s_tvalid & s_tready;

  bra_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (dp_stat),
    .cmd     (dp_cmd),
    .idle    (idle)
  );

  bra_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .in_cmd     (s_tuser),
    .in_idx     (s_tdata[11:0]),
    .in_wv      (s_tdata[12]),
    .in_len     (s_tdata[25:13]),
    .used       (used),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_start  (out_start),
    .out_bit    (out_bit)
  );

  assign m_tdata = {3'b000, out_bit, out_start};

  // one item in flight: after an accept no other item is taken at once
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("item accepted while another is in flight");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == bra_pkg::ST_OK || m_tuser == bra_pkg::ST_NOT_FOUND ||
                  m_tuser == bra_pkg::ST_RANGE))
    else $error("illegal status code");

  // failed commands carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != bra_pkg::ST_OK) |-> (m_tdata == 16'd0))
    else $error("nonzero payload on failed command");

  // a scan that finds a run starts inside the bits in use; other ok
  // results carry a zero start
  a_start_in_use: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == bra_pkg::ST_OK && out_start != '0) |->
      ({1'b0, out_start} < used))
    else $error("run start outside bits in use");

endmodule

// ----- bench/bitmap_run_allocator_core_tb.sv -----
// bitmap_run_allocator_core_tb: self-checking bench for the bitmap run allocator
// drives command items and map_bytes writes, predicts every result from a shadow map
// depends on bra_pkg and bitmap_run_allocator_core
`timescale 1ns / 1ps

module bitmap_run_allocator_core_tb;
  import bra_pkg::*;

  localparam int REG_MAP_BYTES = 0;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int N_SETTINGS    = 8;

  typedef struct {
    cmd_code_t         cmd;
    logic [IDX_W-1:0]  idx;
    logic              wv;
    logic [LEN_W-1:0]  len;
  } cmd_item_t;

  typedef struct {
    logic [1:0]        status;
    logic [IDX_W-1:0]  start_index;
    logic              bit_value;
  } alloc_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    PACE_OPEN,
    PACE_COIN,
    PACE_CHOKE,
    PACE_PULSE
  } pace_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // bit_index[11:0], write_value[12], run_length[25:13]
  logic [1:0]  s_tuser = '0;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // start_index[11:0], bit_value[12]
  logic [1:0]  m_tuser;        // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bitmap_run_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow copy of the allocator: usage map plus the map_bytes register
  logic [MAP_BITS-1:0] usage_shadow = '0;
  logic [MB_W-1:0]     map_bytes_cfg = 10'd512;

  cmd_item_t     cmd_backlog[$];       // items waiting for the driver
  alloc_result_t pending_results[$];   // predicted results, oldest first

  int mismatches = 0;
  int results_seen = 0;
  int ok_count = 0;
  int miss_count = 0;
  int range_count = 0;
  int cycles = 0;

  // bits in use: eight per configured byte, saturating at the map size
  function automatic int used_bits();
    int n;
    n = int'(map_bytes_cfg) * 8;
    return (n > MAP_BITS) ? MAP_BITS : n;
  endfunction

  // apply one command to the shadow map and return the result it must give
  function automatic alloc_result_t apply_alloc_cmd(cmd_item_t it);
    alloc_result_t r;
    int used;
    int run;
    bit hit;
    r.status      = ST_OK;
    r.start_index = '0;
    r.bit_value   = 1'b0;
    used = used_bits();
    case (it.cmd)
      CMD_TEST, CMD_WRITE: begin
        if (int'(it.idx) >= used) begin
          r.status = ST_RANGE;
        end else if (it.cmd == CMD_TEST) begin
          r.bit_value = usage_shadow[it.idx];
        end else begin
          usage_shadow[it.idx] = it.wv;
        end
      end
      CMD_SCAN: begin
        // first fit: lowest start of a run of len free bits below the in-use end
        run = 0;
        hit = 1'b0;
        if (it.len != 0) begin
          for (int i = 0; i < used && !hit; i++) begin
            if (!usage_shadow[i]) begin
              run++;
              if (run == int'(it.len)) begin
                hit = 1'b1;
                r.start_index = IDX_W'(i + 1 - run);
              end
            end else begin
              run = 0;
            end
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      default: begin
        // clear wipes the whole map, also past the in-use end
        usage_shadow = '0;
      end
    endcase
    return r;
  endfunction

  function automatic cmd_item_t mk_cmd(cmd_code_t c, int idx, logic wv, int len);
    cmd_item_t it;
    it.cmd = c;
    it.idx = IDX_W'(idx);
    it.wv  = wv;
    it.len = LEN_W'(len);
    return it;
  endfunction

  // mostly inside the in-use range, sometimes anywhere in the 12-bit field
  function automatic int pick_index(int used);
    if (used == 0 || $urandom_range(0, 9) == 0) return int'(IDX_W'($urandom));
    return $urandom_range(0, used - 1);
  endfunction

  function automatic int pick_len(int used);
    case ($urandom_range(0, 9))
      0:       return int'(LEN_W'($urandom));
      1:       return 0;
      2:       return used;
      3:       return used + 1;
      4, 5:    return $urandom_range(1, 64);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // random commands; about a quarter are runs of writes that build up
  // used and freed stretches, so scans land on a fragmented map
  task automatic queue_random_cmds(input int n_items);
    int used;
    int pick;
    int span;
    int k;
    int base;
    logic fill;
    cmd_code_t op;
    used = used_bits();
    k = 0;
    while (k < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        base = pick_index(used);
        span = $urandom_range(1, 24);
        fill = ($urandom_range(0, 3) != 0);
        for (int j = 0; j < span; j++)
          cmd_backlog.push_back(mk_cmd(CMD_WRITE, base + j, fill, $urandom));
        k += span;
      end else begin
        if (pick < 45) op = CMD_WRITE;
        else if (pick < 65) op = CMD_TEST;
        else if (pick < 97) op = CMD_SCAN;
        else op = CMD_CLEAR;
        cmd_backlog.push_back(mk_cmd(op, pick_index(used), 1'($urandom_range(0, 1)),
                                     pick_len(used)));
        k++;
      end
    end
  endtask

  // block is idle once nothing is queued, presented or outstanding
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // apb write: setup then access; the register takes the value at the access edge
  task automatic write_map_bytes(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_MAP_BYTES * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    map_bytes_cfg = value[MB_W-1:0];
    @(negedge clk);
  endtask

  // command driver: bursts of random length separated by random gaps,
  // some bursts long with no gap, so stalls fall on every scan phase
  int burst_left = 12;
  int gap_left = 0;

  always @(posedge clk) begin : drive_cmds
    logic present;
    present = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_alloc_cmd(cmd_backlog[0]));
        void'(cmd_backlog.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() != 0) begin
        present = 1'b1;
        s_tdata <= {6'b0, cmd_backlog[0].len, cmd_backlog[0].wv, cmd_backlog[0].idx};
        s_tuser <= cmd_backlog[0].cmd;
      end
    end
    s_tvalid <= present;
  end

  // receiver: switches at random between stall patterns
  pace_mode_t pace_mode = PACE_OPEN;
  int pace_left = 0;

  always @(posedge clk) begin : pace_results
    if (pace_left == 0) begin
      pace_mode = pace_mode_t'($urandom_range(0, 3));
      pace_left = $urandom_range(16, 200);
    end else begin
      pace_left--;
    end
    case (pace_mode)
      PACE_OPEN:  m_tready <= 1'b1;
      PACE_COIN:  m_tready <= 1'($urandom_range(0, 1));
      PACE_CHOKE: m_tready <= ($urandom_range(0, 3) == 0);
      default:    m_tready <= pace_left[2];
    endcase
  end

  function automatic void note_mismatch(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    mismatches++;
  endfunction

  // result monitor: each accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result status", -1, int'(m_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status)
          note_mismatch("status", int'(want.status), int'(m_tuser));
        if (m_tdata[IDX_W-1:0] !== want.start_index)
          note_mismatch("start_index", int'(want.start_index), int'(m_tdata[IDX_W-1:0]));
        if (m_tdata[IDX_W] !== want.bit_value)
          note_mismatch("bit_value", int'(want.bit_value), int'(m_tdata[IDX_W]));
        case (want.status)
          ST_OK:        ok_count++;
          ST_NOT_FOUND: miss_count++;
          default:      range_count++;
        endcase
      end
    end
  end

  // watchdog: slowest legal run is far below this
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // settings visited after the reset value; the junk upper bits in one
  // write must be dropped by the 10-bit register
  logic [31:0] cfg_plan [N_SETTINGS-1] = '{32'd1, 32'd0, 32'd1023, 32'd37, 32'd128,
                                            32'hFFFF_FC40, 32'd512};
  int          cfg_items [N_SETTINGS-1] = '{60, 30, 200, 150, 150, 100, 160};

  initial begin : run_plan
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every command, first-fit corner cases
    cmd_backlog.push_back(mk_cmd(CMD_TEST,  0,    1'b0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_TEST,  4095, 1'b1, 8191));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 0,    1'b1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 4095, 1'b1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 2,    1'b1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_TEST,  0,    1'b0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_TEST,  4095, 1'b0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 1));     // single free bit
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 2));     // skips the used bit
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  4095, 1'b1, 4093));  // one short of fitting
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 4092));  // exact fit to the end
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 0));     // zero length
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 8191));  // longer than the map
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 4096));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 0,    1'b0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_CLEAR, 4095, 1'b1, 8191));
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 4096));  // whole map free
    cmd_backlog.push_back(mk_cmd(CMD_TEST,  4095, 1'b0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_WRITE, 4095, 1'b1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 4095));
    cmd_backlog.push_back(mk_cmd(CMD_SCAN,  0,    1'b0, 4096));
    queue_random_cmds(200);
    wait_idle();

    // each setting is entered with the block drained, so the sender
    // pauses until every outstanding result has come back
    for (int p = 0; p < N_SETTINGS - 1; p++) begin
      write_map_bytes(cfg_plan[p]);
      queue_random_cmds(cfg_items[p]);
      wait_idle();
    end

    repeat (32) @(posedge clk);
    $display("covered %0d commands over %0d map_bytes settings, 0 to 1023 bytes",
             results_seen, N_SETTINGS);
    $display("results: %0d ok, %0d no run, %0d out of range, %0d mismatches",
             ok_count, miss_count, range_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bra_pkg.sv
rtl/core/bra_ctrl.sv
rtl/core/bra_dpath.sv
rtl/core/bitmap_run_allocator_core.sv
bench/bitmap_run_allocator_core_tb.sv
